// File: design/evw_pkg.sv
// Package: sizes, types and ring arithmetic for the per-port event window.
package evw_pkg;

  // Block sizing
  localparam int PORTS        = 2;
  localparam int WINDOW_DEPTH = 16;
  localparam int EVENT_BITS   = 32;

  // Fixed field widths
  localparam int WORD_W   = 32;
  localparam int HCOUNT_W = 5;
  localparam int HSLOT_W  = 4;

  // Derived widths
  localparam int PORT_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int ENTRIES = PORTS * WINDOW_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  // Request codes
  localparam logic REQ_APPEND  = 1'b0;
  localparam logic REQ_PUBLISH = 1'b1;

  // Publish sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } pub_state_t;

  // Ring position: base plus offset, wrapped at the window depth
  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] offs);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (SLOT_W+1)'(WINDOW_DEPTH)) begin
      sum = sum - (SLOT_W+1)'(WINDOW_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

// File: design/evw_in_if.sv
// Request channel: valid/ready handshake with append and publish payload.
interface evw_in_if;
  import evw_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic              port;
  logic [WORD_W-1:0] event_word;

  modport source (output valid, output req_type, output port, output event_word,
                  input ready);
  modport sink   (input valid, input req_type, input port, input event_word,
                  output ready);
endinterface

// File: design/evw_out_if.sv
// Result channel: valid/ready handshake with one published window slot.
interface evw_out_if;
  import evw_pkg::*;

  logic                valid;
  logic                ready;
  logic                out_port;
  logic [HCOUNT_W-1:0] held_count;
  logic [WORD_W-1:0]   running_total;
  logic [HSLOT_W-1:0]  slot_index;
  logic [WORD_W-1:0]   held_event;
  logic                event_valid;
  logic                last_result;

  modport source (output valid, output out_port, output held_count,
                  output running_total, output slot_index, output held_event,
                  output event_valid, output last_result, input ready);
  modport sink   (input valid, input out_port, input held_count,
                  input running_total, input slot_index, input held_event,
                  input event_valid, input last_result, output ready);
endinterface

// File: design/evw_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module evw_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/per_port_event_window_unit.sv
// Per-port drop-oldest event window with running totals and publish streaming.
// Append: one append per cycle while no publish is running.
// Publish: each result takes a RAM read state, then an output load state that waits
//   while a result is still held and not taken; no request is taken until the walk ends.
// Reset (synchronous, rst high) clears pointers, fill counts and totals at once;
//   the event RAM is not cleared, as only data of filled slots is ever output.
module per_port_event_window_unit (
  input  logic clk,
  input  logic rst,
  evw_in_if.sink    req,
  evw_out_if.source res
);
  import evw_pkg::*;

  // Per-port window metadata
  logic [SLOT_W-1:0]  oldest [PORTS];
  logic [COUNT_W-1:0] fill   [PORTS];
  logic [WORD_W-1:0]  total  [PORTS];

  pub_state_t         state, state_next;
  logic [PORT_W-1:0]  pub_port;
  logic [SLOT_W-1:0]  pub_slot;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [EVENT_BITS-1:0]  ram_wdata, ram_rdata;

  logic                   take, do_append, do_publish, out_load;
  logic                   port_ok;
  logic [PORT_W-1:0]      app_port;
  logic [SLOT_W-1:0]      app_pos;
  logic                   app_full;
  logic [COUNT_W-1:0]     cur_cnt;
  logic                   cur_empty, slot_last, port_last, run_last;

  evw_ram #(.DEPTH(ENTRIES), .WIDTH(EVENT_BITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request decode; nothing is taken while in reset
  assign req.ready  = (state == S_IDLE) && !rst;
  assign take       = req.valid && req.ready;
  assign port_ok    = (32'(req.port) < 32'(PORTS));
  assign app_port   = PORT_W'(req.port);
  assign do_append  = take && (req.req_type == REQ_APPEND) && port_ok;
  assign do_publish = take && (req.req_type == REQ_PUBLISH);

  // Append slot: oldest slot when full, else first free slot
  assign app_full = (fill[app_port] >= COUNT_W'(WINDOW_DEPTH));
  assign app_pos  = app_full ? oldest[app_port]
                             : ring_add(oldest[app_port], SLOT_W'(fill[app_port]));

  // Publish position bookkeeping
  assign cur_cnt   = fill[pub_port];
  assign cur_empty = (cur_cnt == '0);
  assign slot_last = cur_empty || (pub_slot == SLOT_W'(cur_cnt - 1'b1));
  assign port_last = (pub_port == PORT_W'(PORTS - 1));
  assign run_last  = slot_last && port_last;
  assign out_load  = (state == S_LOAD) && (!res.valid || res.ready);

  // RAM port control
  always_comb begin
    ram_we    = do_append;
    ram_waddr = ADDR_W'(app_port) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(app_pos);
    ram_wdata = EVENT_BITS'(req.event_word);
    ram_re    = (state == S_READ);
    ram_raddr = ADDR_W'(pub_port) * ADDR_W'(WINDOW_DEPTH)
              + ADDR_W'(ring_add(oldest[pub_port], pub_slot));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (do_publish) state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: if (out_load) state_next = run_last ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Metadata update on append
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORTS; i++) begin
        oldest[i] <= '0;
        fill[i]   <= '0;
        total[i]  <= '0;
      end
    end else if (do_append) begin
      total[app_port] <= total[app_port] + 1'b1;
      if (app_full) begin
        oldest[app_port] <= ring_add(oldest[app_port], SLOT_W'(1));
      end else begin
        fill[app_port] <= fill[app_port] + 1'b1;
      end
    end
  end

  // Publish walk: slot within port, then next port
  always_ff @(posedge clk) begin
    if (rst) begin
      pub_port <= '0;
      pub_slot <= '0;
    end else if (do_publish) begin
      pub_port <= '0;
      pub_slot <= '0;
    end else if (out_load) begin
      if (slot_last) begin
        pub_slot <= '0;
        pub_port <= port_last ? '0 : pub_port + 1'b1;
      end else begin
        pub_slot <= pub_slot + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.out_port      <= 1'(pub_port);
      res.held_count    <= HCOUNT_W'(cur_cnt);
      res.running_total <= total[pub_port];
      res.slot_index    <= HSLOT_W'(pub_slot);
      res.held_event    <= cur_empty ? '0 : WORD_W'(ram_rdata);
      res.event_valid   <= !cur_empty;
      res.last_result   <= run_last;
    end
  end

endmodule

// File: dv/tb.sv
// Testbench for per_port_event_window_unit: directed and random traffic, scoreboard check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import evw_pkg::*;

  localparam int RANDOM_ITEMS   = 410;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // One published window slot as seen on the result channel
  typedef struct {
    logic                out_port;
    logic [HCOUNT_W-1:0] held_count;
    logic [WORD_W-1:0]   running_total;
    logic [HSLOT_W-1:0]  slot_index;
    logic [WORD_W-1:0]   held_event;
    logic                event_valid;
    logic                last_result;
  } window_slot_t;

  // Shadow copy of the per-port windows plus the queue of slots still to be published
  class window_scoreboard;
    bit [WORD_W-1:0] ring [PORTS][WINDOW_DEPTH];
    int unsigned     head [PORTS];
    int unsigned     fill [PORTS];
    bit [WORD_W-1:0] total [PORTS];
    window_slot_t    slot_queue [$];
    int unsigned     errors;

    task report(string msg);
      errors++;
      $display("tb: mismatch: %s", msg);
    endtask

    function int unsigned pending();
      return slot_queue.size();
    endfunction

    // Update the shadow windows for one accepted transaction
    function void note_request(logic rt, logic pt, logic [WORD_W-1:0] w);
      logic [63:0]  mask;
      int unsigned  p;
      int unsigned  pos;
      int unsigned  produced;
      window_slot_t s;
      if (rt == REQ_APPEND) begin
        p = int'(pt);
        if (p >= PORTS) return;
        mask = (EVENT_BITS >= 64) ? '1 : ((64'd1 << EVENT_BITS) - 64'd1);
        if (fill[p] >= WINDOW_DEPTH) begin
          // full window: overwrite the oldest and move the head on
          pos = head[p] % WINDOW_DEPTH;
          head[p] = (head[p] + 1) % WINDOW_DEPTH;
          fill[p] = WINDOW_DEPTH;
        end else begin
          pos = (head[p] + fill[p]) % WINDOW_DEPTH;
          fill[p]++;
        end
        ring[p][pos] = WORD_W'(64'(w) & mask);
        total[p] = total[p] + 1'b1;
        return;
      end
      // publish: port by port, oldest slot first
      produced = 0;
      for (int unsigned q = 0; q < PORTS; q++) begin
        s.out_port      = q[0];
        s.held_count    = HCOUNT_W'(fill[q]);
        s.running_total = total[q];
        s.last_result   = 1'b0;
        if (fill[q] == 0) begin
          s.slot_index  = '0;
          s.held_event  = '0;
          s.event_valid = 1'b0;
          slot_queue = {slot_queue, s};
          produced++;
        end else begin
          for (int unsigned k = 0; k < fill[q]; k++) begin
            s.slot_index  = HSLOT_W'(k);
            s.held_event  = ring[q][(head[q] + k) % WINDOW_DEPTH];
            s.event_valid = 1'b1;
            slot_queue = {slot_queue, s};
            produced++;
          end
        end
      end
      if (produced != 0) slot_queue[slot_queue.size() - 1].last_result = 1'b1;
    endfunction

    // Compare one accepted result with the oldest expected slot
    task check_result(window_slot_t got);
      window_slot_t exp;
      string        diffs;
      if (slot_queue.size() == 0) begin
        report($sformatf("unexpected result port=%0d slot=%0d",
                         got.out_port, got.slot_index));
        return;
      end
      exp = slot_queue.pop_front();
      diffs = "";
      if (got.out_port      !== exp.out_port)      diffs = {diffs, " out_port"};
      if (got.held_count    !== exp.held_count)    diffs = {diffs, " held_count"};
      if (got.running_total !== exp.running_total) diffs = {diffs, " running_total"};
      if (got.slot_index    !== exp.slot_index)    diffs = {diffs, " slot_index"};
      if (got.held_event    !== exp.held_event)    diffs = {diffs, " held_event"};
      if (got.event_valid   !== exp.event_valid)   diffs = {diffs, " event_valid"};
      if (got.last_result   !== exp.last_result)   diffs = {diffs, " last_result"};
      if (diffs != "") begin
        report($sformatf({"port %0d slot %0d:%s",
                          " (got cnt=%0d tot=%0d ev=%h v=%b l=%b,",
                          " exp cnt=%0d tot=%0d ev=%h v=%b l=%b)"},
                         exp.out_port, exp.slot_index, diffs,
                         got.held_count, got.running_total, got.held_event,
                         got.event_valid, got.last_result,
                         exp.held_count, exp.running_total, exp.held_event,
                         exp.event_valid, exp.last_result));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   no_stall;
  int unsigned ready_hold;
  int unsigned idle_cycles;
  window_scoreboard sb = new;
  window_slot_t got_slot;

  evw_in_if  req_ch ();
  evw_out_if res_ch ();

  per_port_event_window_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one transaction on the request channel and wait for it to be taken
  task automatic send_request(input logic rt, input logic pt, input logic [WORD_W-1:0] w);
    int unsigned gap;
    gap = no_stall ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.port       <= pt;
    req_ch.event_word <= w;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(rt, pt, w);
    @(negedge clk);
  endtask

  // Result side back-pressure
  initial res_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      res_ch.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!no_stall && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  // Result capture
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got_slot.out_port      = res_ch.out_port;
      got_slot.held_count    = res_ch.held_count;
      got_slot.running_total = res_ch.running_total;
      got_slot.slot_index    = res_ch.slot_index;
      got_slot.held_event    = res_ch.held_event;
      got_slot.event_valid   = res_ch.event_valid;
      got_slot.last_result   = res_ch.last_result;
      sb.check_result(got_slot);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned      pick;
    int unsigned      port_bias;
    logic             pt;
    logic [WORD_W-1:0] word;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_APPEND;
    req_ch.port       = 1'b0;
    req_ch.event_word = '0;
    rst        = 1'b1;
    no_stall   = 1'b0;
    ready_hold = 0;
    port_bias  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty ports, extreme words, overflow of a full window
    send_request(REQ_PUBLISH, 1'b0, '0);
    send_request(REQ_APPEND, 1'b0, '0);
    send_request(REQ_APPEND, 1'b0, '1);
    send_request(REQ_PUBLISH, 1'b1, '1);
    for (int i = 0; i < WINDOW_DEPTH + 1; i++) begin
      send_request(REQ_APPEND, 1'b1, (i == 0) ? 32'h8000_0001 : $urandom);
    end
    send_request(REQ_PUBLISH, 1'b0, 32'h5555_aaaa);

    // random: mostly appends, occasional publish, phases with port bias and no idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        no_stall  = ($urandom_range(0, 4) == 0);
        port_bias = $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 9);
      word = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      case (port_bias)
        1: pt = 1'b0;
        2: pt = 1'b1;
        default: pt = 1'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 99) < 8) begin
        send_request(REQ_PUBLISH, 1'($urandom_range(0, 1)), word);
      end else begin
        send_request(REQ_APPEND, pt, word);
      end
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
